// ----- rtl/core/lfsd_pkg.sv -----
// Shared types and constants of the lidar frame sample decoder.
package lfsd_pkg;

  localparam logic [7:0]  SYNC_A      = 8'hAA;
  localparam logic [7:0]  SYNC_B      = 8'h55;
  localparam logic [15:0] FULL_TURN   = 16'd23040;
  localparam logic [7:0]  MAX_SAMPLES = 8'd32;

  localparam logic [3:0] HDR_FIRST = 4'd2;
  localparam logic [3:0] HDR_MODE  = 4'd2;
  localparam logic [3:0] HDR_COUNT = 4'd3;
  localparam logic [3:0] HDR_FSA_L = 4'd4;
  localparam logic [3:0] HDR_FSA_H = 4'd5;
  localparam logic [3:0] HDR_LSA_L = 4'd6;
  localparam logic [3:0] HDR_LSA_H = 4'd7;
  localparam logic [3:0] HDR_LAST  = 4'd9;

  localparam int unsigned ANGLE_W     = 15;
  localparam int unsigned ANGLE_INT_W = 32;
  localparam int unsigned DIST_W      = 14;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONF_THR  = 2'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0]  range_mm;
    logic [7:0]         intensity;
    logic [ANGLE_W-1:0] angle_64ths;
    logic               accepted;
    logic [4:0]         sample_index;
    logic               last_of_packet;
    logic               revolution_end;
  } out_item_t;

endpackage

// ----- rtl/core/lfsd_stream_if.sv -----
// Valid/ready stream channel carrying one payload item per transaction.
interface lfsd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/lfsd_divider.sv -----
// Restoring radix-2 divider producing the angle step one quotient bit per cycle.
module lfsd_divider #(
  parameter int unsigned DivW = 48
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [7:0]      divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0] quot_q, quot_d;
  logic [7:0]      rem_q, rem_d;
  logic [7:0]      dsr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [8:0]      trial;
  logic            fits;

  always_comb begin
    trial  = {rem_q, quot_q[DivW-1]};
    fits   = trial >= {1'b0, dsr_q};
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = CntW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quot_d = {quot_q[DivW-2:0], fits};
      rem_d  = fits ? 8'(trial - {1'b0, dsr_q}) : trial[7:0];
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- rtl/core/lidar_frame_sample_decoder.sv -----
// Top level of the lidar frame sample decoder: byte parser, sample decode and output register.
//
// Usage: in_i carries one received serial byte per transaction (rx_byte). The decoder
// hunts for the sync pair 0xAA 0x55, collects the 10-byte packet header and then decodes
// count samples of three bytes each. After the third byte of a sample one transaction
// leaves on out_o with distance, intensity, interpolated angle, accept flag, sample
// index and end-of-packet / end-of-revolution marks. Header and sync bytes give no result.
// Latency: a result is valid in the cycle after its third sample byte is accepted.
// Throughput: one byte per cycle, except after the last header byte of a packet with
// more than one sample: the angle step divider then runs 32 + AngleFracBits steps, one
// quotient bit per cycle, and in_i.ready stays low until the divider is done.
// The single output register holds a result until it is taken; while it is full and
// out_o.ready is low, in_i.ready is low as well.
// The configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) writes minimum distance,
// maximum distance and intensity threshold; write it only while the decoder is idle.
// Reset (rst_ni, asynchronous, active low) returns the parser to sync hunt, empties the
// output register and loads the register defaults 0, 16383 and 5. No clearing pass.
module lidar_frame_sample_decoder #(
  parameter int unsigned AngleFracBits = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [lfsd_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [lfsd_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  lfsd_stream_if.sink                            in_i,
  lfsd_stream_if.source                          out_o
);

  localparam int unsigned IntW = lfsd_pkg::ANGLE_INT_W;
  localparam int unsigned DivW = IntW + AngleFracBits;
  localparam int unsigned AccW = IntW + AngleFracBits;

  typedef enum logic [2:0] {
    ST_WAIT1,
    ST_WAIT2,
    ST_HEADER,
    ST_DIVIDE,
    ST_SAMPLES
  } state_e;

  state_e state_q, state_d;

  logic [lfsd_pkg::DIST_W-1:0] min_dist_q, min_dist_d;
  logic [lfsd_pkg::DIST_W-1:0] max_dist_q, max_dist_d;
  logic [7:0]                  conf_thr_q, conf_thr_d;

  logic [3:0]      byte_cnt_q, byte_cnt_d;
  logic [1:0]      phase_q, phase_d;
  logic [7:0]      cur_q, cur_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [DivW-1:0] inc_q, inc_d;
  logic            out_valid_q, out_valid_d;
  lfsd_pkg::out_item_t out_data_q, out_data_d;

  logic [7:0]  hdr_mode_q;
  logic [7:0]  hdr_count_q;
  logic [15:0] hdr_fsa_q;
  logic [15:0] hdr_lsa_q;
  logic [7:0]  lo_q;
  logic [7:0]  mid_q;

  logic            in_ready;
  logic            in_acc;
  logic            out_fire;
  logic [7:0]      rx;
  logic [14:0]     fsa;
  logic [14:0]     lsa;
  logic [15:0]     lsa_adj;
  logic [IntW-1:0] diff;
  logic            count_ok;
  logic            div_start;
  logic            div_done;
  logic [DivW-1:0] div_quot;

  logic [lfsd_pkg::DIST_W-1:0] smp_range;
  logic [7:0]                  inten;
  logic [IntW-1:0]             ang_int;
  logic [IntW-1:0]             ang_wrap;
  logic                        last;

  assign in_ready = (state_q != ST_DIVIDE) && (!out_valid_q || out_o.ready);
  assign in_acc   = in_i.valid && in_ready;
  assign out_fire = out_valid_q && out_o.ready;
  assign rx       = in_i.data.rx_byte;

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign fsa     = hdr_fsa_q[15:1];
  assign lsa     = hdr_lsa_q[15:1];
  assign lsa_adj = (lsa < fsa) ? ({1'b0, lsa} + lfsd_pkg::FULL_TURN) : {1'b0, lsa};
  assign diff    = IntW'(lsa_adj) - IntW'(fsa);
  assign count_ok = (hdr_count_q != 8'd0) && (hdr_count_q <= lfsd_pkg::MAX_SAMPLES);
  assign div_start = in_acc && (state_q == ST_HEADER) && (byte_cnt_q == lfsd_pkg::HDR_LAST)
                     && count_ok && (hdr_count_q > 8'd1);

  assign smp_range = {rx, mid_q[7:2]};
  assign inten     = {mid_q[1:0], lo_q[7:2]};
  assign ang_int   = acc_q[AccW-1 -: IntW];
  assign ang_wrap  = (ang_int >= IntW'(lfsd_pkg::FULL_TURN))
                     ? (ang_int - IntW'(lfsd_pkg::FULL_TURN)) : ang_int;
  assign last      = ({1'b0, cur_q} + 9'd1) >= {1'b0, hdr_count_q};

  lfsd_divider #(
    .DivW(DivW)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({diff, {AngleFracBits{1'b0}}}),
    .divisor_i  (hdr_count_q - 8'd1),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    min_dist_d  = min_dist_q;
    max_dist_d  = max_dist_q;
    conf_thr_d  = conf_thr_q;
    byte_cnt_d  = byte_cnt_q;
    phase_d     = phase_q;
    cur_d       = cur_q;
    acc_d       = acc_q;
    inc_d       = inc_q;
    out_valid_d = out_valid_q && !out_fire;
    out_data_d  = out_data_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        lfsd_pkg::CFG_MIN_DIST: min_dist_d = cfg_data_i;
        lfsd_pkg::CFG_MAX_DIST: max_dist_d = cfg_data_i;
        lfsd_pkg::CFG_CONF_THR: conf_thr_d = cfg_data_i[7:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_WAIT1: begin
        if (in_acc && rx == lfsd_pkg::SYNC_A) begin
          state_d = ST_WAIT2;
        end
      end
      ST_WAIT2: begin
        if (in_acc) begin
          if (rx == lfsd_pkg::SYNC_B) begin
            state_d    = ST_HEADER;
            byte_cnt_d = lfsd_pkg::HDR_FIRST;
          end else if (rx != lfsd_pkg::SYNC_A) begin
            state_d = ST_WAIT1;
          end
        end
      end
      ST_HEADER: begin
        if (in_acc) begin
          byte_cnt_d = byte_cnt_q + 4'd1;
          if (byte_cnt_q == lfsd_pkg::HDR_LAST) begin
            if (!count_ok) begin
              state_d = ST_WAIT1;
            end else begin
              acc_d   = AccW'({fsa, {AngleFracBits{1'b0}}});
              cur_d   = 8'd0;
              phase_d = 2'd0;
              inc_d   = '0;
              state_d = (hdr_count_q > 8'd1) ? ST_DIVIDE : ST_SAMPLES;
            end
          end
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          inc_d   = div_quot;
          state_d = ST_SAMPLES;
        end
      end
      ST_SAMPLES: begin
        if (in_acc) begin
          if (phase_q != 2'd2) begin
            phase_d = phase_q + 2'd1;
          end else begin
            phase_d                   = 2'd0;
            out_valid_d               = 1'b1;
            out_data_d.range_mm       = smp_range;
            out_data_d.intensity      = inten;
            out_data_d.angle_64ths    = ang_wrap[lfsd_pkg::ANGLE_W-1:0];
            out_data_d.accepted       = (smp_range >= min_dist_q) && (smp_range <= max_dist_q)
                                        && (inten >= conf_thr_q);
            out_data_d.sample_index   = cur_q[4:0];
            out_data_d.last_of_packet = last;
            out_data_d.revolution_end = last && !hdr_mode_q[0];
            acc_d                     = acc_q + AccW'(inc_q);
            cur_d                     = cur_q + 8'd1;
            if (last) begin
              state_d = ST_WAIT1;
            end
          end
        end
      end
      default: state_d = ST_WAIT1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WAIT1;
      min_dist_q  <= '0;
      max_dist_q  <= '1;
      conf_thr_q  <= 8'd5;
      byte_cnt_q  <= '0;
      phase_q     <= '0;
      cur_q       <= '0;
      acc_q       <= '0;
      inc_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      min_dist_q  <= min_dist_d;
      max_dist_q  <= max_dist_d;
      conf_thr_q  <= conf_thr_d;
      byte_cnt_q  <= byte_cnt_d;
      phase_q     <= phase_d;
      cur_q       <= cur_d;
      acc_q       <= acc_d;
      inc_q       <= inc_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && state_q == ST_HEADER) begin
      case (byte_cnt_q)
        lfsd_pkg::HDR_MODE:  hdr_mode_q       <= rx;
        lfsd_pkg::HDR_COUNT: hdr_count_q      <= rx;
        lfsd_pkg::HDR_FSA_L: hdr_fsa_q[7:0]   <= rx;
        lfsd_pkg::HDR_FSA_H: hdr_fsa_q[15:8]  <= rx;
        lfsd_pkg::HDR_LSA_L: hdr_lsa_q[7:0]   <= rx;
        lfsd_pkg::HDR_LSA_H: hdr_lsa_q[15:8]  <= rx;
        default: ;
      endcase
    end
    if (in_acc && state_q == ST_SAMPLES) begin
      if (phase_q == 2'd0) begin
        lo_q <= rx;
      end
      if (phase_q == 2'd1) begin
        mid_q <= rx;
      end
    end
  end

endmodule

// ----- sim/lfsd_checker.sv -----
`timescale 1ns / 100ps
// Checker of the lidar frame sample decoder: predicts samples from accepted bytes and compares.
module lfsd_checker #(
  parameter int unsigned AngleFracBits = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lfsd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lfsd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  lfsd_pkg::in_item_t              in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  lfsd_pkg::out_item_t             out_data_i,
  output int unsigned                     mismatch_count_o,
  output int unsigned                     pending_count_o
);

  localparam int unsigned HeaderLen = 10;
  localparam int unsigned MaxPrinted = 100;

  typedef enum logic [1:0] {
    HUNT_SYNC_A,
    HUNT_SYNC_B,
    PARSE_HEADER,
    PARSE_SAMPLES
  } parse_phase_e;

  parse_phase_e        parse_q;
  logic [7:0]          hdr_q [HeaderLen];
  logic [6:0]          hdr_cnt_q;
  logic [1:0]          byte_phase_q;
  logic [7:0]          held_q [2];
  logic [7:0]          sample_cnt_q;
  logic [63:0]         angle_acc_q;
  logic [63:0]         angle_step_q;
  logic [13:0]         min_dist_q;
  logic [13:0]         max_dist_q;
  logic [7:0]          conf_thr_q;
  lfsd_pkg::out_item_t expected_samples [$];
  lfsd_pkg::out_item_t want;
  int unsigned         sample_seen;

  task automatic report_mismatch(input string msg);
    if (mismatch_count_o < MaxPrinted) begin
      $display("checker: sample %0d: %s", sample_seen, msg);
    end
    mismatch_count_o++;
  endtask

  task automatic compare_field(input string field, input logic [31:0] got,
                               input logic [31:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("%s got %0d want %0d", field, got, exp_val));
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [31:0]         first_ang;
    logic [31:0]         last_ang;
    logic [31:0]         ang;
    logic [7:0]          count;
    logic                last;
    lfsd_pkg::out_item_t s;
    case (parse_q)
      HUNT_SYNC_A: begin
        if (b == lfsd_pkg::SYNC_A) begin
          hdr_q[0]  = b;
          hdr_cnt_q = 7'd1;
          parse_q   = HUNT_SYNC_B;
        end
      end
      HUNT_SYNC_B: begin
        if (b == lfsd_pkg::SYNC_B) begin
          hdr_q[1]  = b;
          hdr_cnt_q = 7'd2;
          parse_q   = PARSE_HEADER;
        end else if (b == lfsd_pkg::SYNC_A) begin
          hdr_q[0]  = b;
          hdr_cnt_q = 7'd1;
        end else begin
          parse_q   = HUNT_SYNC_A;
          hdr_cnt_q = 7'd0;
        end
      end
      PARSE_HEADER: begin
        if (hdr_cnt_q < HeaderLen) hdr_q[hdr_cnt_q] = b;
        hdr_cnt_q = hdr_cnt_q + 7'd1;
        if (hdr_cnt_q >= HeaderLen) begin
          count = hdr_q[lfsd_pkg::HDR_COUNT];
          if (count == 8'd0 || count > lfsd_pkg::MAX_SAMPLES) begin
            parse_q   = HUNT_SYNC_A;
            hdr_cnt_q = 7'd0;
          end else begin
            first_ang = {16'd0, hdr_q[lfsd_pkg::HDR_FSA_H], hdr_q[lfsd_pkg::HDR_FSA_L]} >> 1;
            last_ang  = {16'd0, hdr_q[lfsd_pkg::HDR_LSA_H], hdr_q[lfsd_pkg::HDR_LSA_L]} >> 1;
            if (last_ang < first_ang) last_ang = last_ang + 32'(lfsd_pkg::FULL_TURN);
            angle_acc_q = 64'(first_ang) << AngleFracBits;
            if (count > 8'd1) begin
              angle_step_q = (64'(last_ang - first_ang) << AngleFracBits) /
                             64'(count - 8'd1);
            end else begin
              angle_step_q = 64'd0;
            end
            sample_cnt_q = 8'd0;
            byte_phase_q = 2'd0;
            parse_q      = PARSE_SAMPLES;
          end
        end
      end
      default: begin
        if (byte_phase_q < 2'd2) begin
          held_q[byte_phase_q] = b;
          byte_phase_q = byte_phase_q + 2'd1;
        end else begin
          byte_phase_q = 2'd0;
          count = hdr_q[lfsd_pkg::HDR_COUNT];
          s.range_mm  = {b, held_q[1][7:2]};
          s.intensity = {held_q[1][1:0], held_q[0][7:2]};
          ang = 32'(angle_acc_q >> AngleFracBits);
          if (ang >= 32'(lfsd_pkg::FULL_TURN)) ang = ang - 32'(lfsd_pkg::FULL_TURN);
          s.angle_64ths    = ang[lfsd_pkg::ANGLE_W-1:0];
          last             = (int'(sample_cnt_q) + 1 >= int'(count));
          s.accepted       = (s.range_mm >= min_dist_q) && (s.range_mm <= max_dist_q) &&
                             (s.intensity >= conf_thr_q);
          s.sample_index   = sample_cnt_q[4:0];
          s.last_of_packet = last;
          s.revolution_end = last && !hdr_q[lfsd_pkg::HDR_MODE][0];
          expected_samples.push_back(s);
          angle_acc_q  = angle_acc_q + angle_step_q;
          sample_cnt_q = sample_cnt_q + 8'd1;
          if (last) begin
            parse_q   = HUNT_SYNC_A;
            hdr_cnt_q = 7'd0;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q      = HUNT_SYNC_A;
      hdr_cnt_q    = 7'd0;
      byte_phase_q = 2'd0;
      sample_cnt_q = 8'd0;
      angle_acc_q  = 64'd0;
      angle_step_q = 64'd0;
      held_q[0]    = 8'd0;
      held_q[1]    = 8'd0;
      for (int i = 0; i < HeaderLen; i++) hdr_q[i] = 8'd0;
      min_dist_q   = 14'd0;
      max_dist_q   = 14'd16383;
      conf_thr_q   = 8'd5;
      expected_samples.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
      sample_seen      = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("sample with no transaction pending");
        end else begin
          want = expected_samples.pop_front();
          compare_field("range_mm", 32'(out_data_i.range_mm), 32'(want.range_mm));
          compare_field("intensity", 32'(out_data_i.intensity), 32'(want.intensity));
          compare_field("angle_64ths", 32'(out_data_i.angle_64ths), 32'(want.angle_64ths));
          compare_field("accepted", 32'(out_data_i.accepted), 32'(want.accepted));
          compare_field("sample_index", 32'(out_data_i.sample_index),
                        32'(want.sample_index));
          compare_field("last_of_packet", 32'(out_data_i.last_of_packet),
                        32'(want.last_of_packet));
          compare_field("revolution_end", 32'(out_data_i.revolution_end),
                        32'(want.revolution_end));
        end
        sample_seen++;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lfsd_pkg::CFG_MIN_DIST: min_dist_q = cfg_data_i;
          lfsd_pkg::CFG_MAX_DIST: max_dist_q = cfg_data_i;
          lfsd_pkg::CFG_CONF_THR: conf_thr_q = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) decode_byte(in_data_i.rx_byte);
      pending_count_o = expected_samples.size();
    end
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Top of the decoder testbench: clock, reset, byte stimulus, output stalls and verdict.
module testbench;

  localparam int unsigned AngleFracBits = 16;
  localparam int unsigned RandomBytes   = 1750;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned SettleCycles  = 2 * AngleFracBits + 40;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [lfsd_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [lfsd_pkg::CFG_DATA_W-1:0] cfg_data;
  int unsigned                     mismatches;
  int unsigned                     pending;
  int unsigned                     burst_left;
  int unsigned                     packet_bytes;

  lfsd_stream_if #(.payload_t(lfsd_pkg::in_item_t))  in_ch ();
  lfsd_stream_if #(.payload_t(lfsd_pkg::out_item_t)) out_ch ();

  lidar_frame_sample_decoder #(
    .AngleFracBits(AngleFracBits)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_ch),
    .out_o     (out_ch)
  );

  lfsd_checker #(
    .AngleFracBits(AngleFracBits)
  ) i_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_ch.valid),
    .in_ready_i      (in_ch.ready),
    .in_data_i       (in_ch.data),
    .out_valid_i     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .out_data_i      (out_ch.data),
    .mismatch_count_o(mismatches),
    .pending_count_o (pending)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned cyc;
    out_ch.ready = 1'b0;
    cyc = 0;
    forever begin
      @(negedge clk_i);
      case ((cyc / 97) % 4)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= (cyc % 5 == 0);
        default: out_ch.ready <= ($urandom_range(0, 15) != 0);
      endcase
      cyc++;
    end
  end

  function automatic logic [7:0] biased_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return lfsd_pkg::SYNC_A;
      3: return lfsd_pkg::SYNC_B;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_ch.valid        <= 1'b1;
    in_ch.data.rx_byte <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    burst_left--;
  endtask

  task automatic send_packet(input bit truncate);
    logic [7:0]  count;
    logic [7:0]  frame [$];
    int unsigned sel;
    int unsigned len;
    sel = $urandom_range(0, 7);
    case (sel)
      0: count = 8'd1;
      1: count = lfsd_pkg::MAX_SAMPLES;
      2: count = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(33, 255));
      default: count = 8'($urandom_range(2, 31));
    endcase
    frame.push_back(lfsd_pkg::SYNC_A);
    frame.push_back(lfsd_pkg::SYNC_B);
    frame.push_back(8'($urandom));
    frame.push_back(count);
    repeat (6) frame.push_back(biased_byte());
    if (count != 8'd0 && count <= lfsd_pkg::MAX_SAMPLES) begin
      repeat (3 * count) frame.push_back(biased_byte());
    end
    len = truncate ? $urandom_range(3, frame.size() - 1) : frame.size();
    for (int k = 0; k < len; k++) send_byte(frame[k]);
    if (sel != 2) packet_bytes += len;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [13:0] min_mm, input logic [13:0] max_mm,
                                input logic [7:0] thr);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= lfsd_pkg::CFG_MIN_DIST;
    cfg_data <= min_mm;
    @(negedge clk_i);
    cfg_idx  <= lfsd_pkg::CFG_MAX_DIST;
    cfg_data <= max_mm;
    @(negedge clk_i);
    cfg_idx  <= lfsd_pkg::CFG_CONF_THR;
    cfg_data <= lfsd_pkg::CFG_DATA_W'(thr);
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    logic [7:0]  directed [$];
    logic [13:0] min_mm;
    logic [13:0] max_mm;
    logic [7:0]  thr;
    int unsigned target;
    int unsigned pick;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = lfsd_pkg::CFG_MIN_DIST;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    burst_left    = 0;
    packet_bytes  = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // stray byte, broken sync, repeated sync byte, then a wrapping two-sample packet
    directed = '{8'h55, 8'hAA, 8'h13, 8'hAA, 8'hAA, 8'h55,
                 8'h00, 8'h02, 8'hFE, 8'hFF, 8'h00, 8'h00, 8'h34, 8'h12,
                 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF};
    foreach (directed[k]) send_byte(directed[k]);

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      case (p)
        0: begin min_mm = 14'd0;     max_mm = 14'd16383; thr = 8'd0;   end
        1: begin min_mm = 14'd16383; max_mm = 14'd16383; thr = 8'd255; end
        2: begin min_mm = 14'd9000;  max_mm = 14'd100;   thr = 8'd5;   end
        3: begin min_mm = 14'd0;     max_mm = 14'd0;     thr = 8'd0;   end
        default: begin
          min_mm = 14'($urandom_range(0, 8000));
          max_mm = 14'($urandom_range(min_mm, 16383));
          thr    = 8'($urandom_range(0, 255));
        end
      endcase
      apply_settings(min_mm, max_mm, thr);
      target = packet_bytes + RandomBytes / NumPhases;
      while (packet_bytes < target) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          send_packet(1'b0);
        end else if (pick < 8) begin
          send_packet(1'b1);
        end else begin
          repeat ($urandom_range(1, 6)) send_byte(biased_byte());
        end
      end
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
